/* src/cdr_pkg.sv */
// Shared types, constants and helpers of the central-difference residual block.
`default_nettype none
package cdr_pkg;

  localparam int unsigned CDR_MAX_PDE   = 16;
  localparam int unsigned CDR_CNT_W     = 5;
  localparam int unsigned CDR_COMP_W    = 4;
  localparam int unsigned CDR_DIV_STEPS = 33;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_FEW = 2'd1;
  localparam logic [1:0] ST_ZERO_SP = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_INV,
    OP_DIV_START,
    OP_SET_INV,
    OP_QMUL,
    OP_QSAT,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_M5,
    OP_OUT_EDGE,
    OP_OUT_RES,
    OP_OUT_RIGHT
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       first_comp;
    logic       last_node;
    logic       d_zero;
    logic       inv_zero;
    logic       div_done;
    logic       out_free;
  } dp_sts_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_0000_0000_7FFF_FFFF;
    lo = -66'sh0_0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

/* src/cdr_div.sv */
// Restoring divider that forms 2^32 / divisor one quotient bit per cycle.
`default_nettype none
module cdr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [32:0] quot_o
);
  import cdr_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] dsr_q;
  logic [32:0] quot_q;
  logic [32:0] sh;
  logic [32:0] diff;
  logic        ge;

  // The dividend is a single one followed by zeros.
  assign sh   = {rem_q, (cnt_q == 6'(CDR_DIV_STEPS))};
  assign diff = sh - {1'b0, dsr_q};
  assign ge   = sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(CDR_DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dsr_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[31:0] : sh[31:0];
      quot_q <= {quot_q[31:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

/* src/cdr_dp.sv */
// Datapath: node stores, positions, spacing reciprocal, shared multiplier, result register.
`default_nettype none
module cdr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdr_pkg::dp_cmd_t      cmd_i,
  output cdr_pkg::dp_sts_t      sts_o,
  input  logic                  cfg_valid_i,
  input  logic [4:0]            cfg_data_i,
  input  logic signed [31:0]    value_i,
  input  logic [31:0]           node_pos_i,
  input  logic signed [31:0]    src_term_i,
  input  logic signed [31:0]    diff_coef_i,
  input  logic signed [31:0]    velocity_i,
  input  logic                  last_node_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic signed [31:0]    residual_o,
  output logic [3:0]            component_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);
  import cdr_pkg::*;

  logic [CDR_CNT_W-1:0]  pde_q;
  logic [CDR_CNT_W-1:0]  n_eff;
  logic [CDR_COMP_W-1:0] comp_q;
  logic [1:0]            phase_q;
  logic [31:0]           pos2_q, pos1_q;
  logic signed [31:0]    inv_q, q_q;

  logic signed [31:0] left_mem [CDR_MAX_PDE];
  logic signed [31:0] cent_mem [CDR_MAX_PDE];
  logic signed [31:0] src_mem  [CDR_MAX_PDE];
  logic signed [31:0] dif_mem  [CDR_MAX_PDE];
  logic signed [31:0] vel_mem  [CDR_MAX_PDE];

  logic signed [31:0]    r_q, l_q, m_q, src_q, dif_q, vel_q;
  logic signed [32:0]    d_q;
  logic                  lastn_q;
  logic [CDR_COMP_W-1:0] cidx_q;
  logic [1:0]            ph_q;

  logic signed [31:0] ux_q, uxx_q, pv_q, pd_q;
  logic signed [65:0] prod_q;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] prod_sat;

  logic                  out_vld_q;
  logic signed [31:0]    out_res_q;
  logic [CDR_COMP_W-1:0] out_comp_q;
  logic [1:0]            out_st_q;
  logic                  out_last_q;
  logic                  out_free;

  logic        node_end;
  logic        div_done;
  logic [32:0] quot;
  logic [32:0] d_abs;
  logic signed [31:0] inv_new;
  logic signed [31:0] res_sum;

  assign n_eff = (pde_q == '0) ? CDR_CNT_W'(1) :
                 (pde_q > CDR_CNT_W'(CDR_MAX_PDE)) ? CDR_CNT_W'(CDR_MAX_PDE) : pde_q;
  assign node_end = ({1'b0, comp_q} + CDR_CNT_W'(1)) >= n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pde_q <= CDR_CNT_W'(1);
    end else if (cfg_valid_i) begin
      pde_q <= cfg_data_i;
    end
  end

  // Node bookkeeping advances when the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q  <= '0;
      phase_q <= '0;
      pos2_q  <= '0;
      pos1_q  <= '0;
    end else if (cmd_i.accept) begin
      if (node_end) begin
        comp_q <= '0;
        if (last_node_i) begin
          phase_q <= '0;
          pos2_q  <= '0;
          pos1_q  <= '0;
        end else begin
          if (phase_q < 2'd2) begin
            phase_q <= phase_q + 2'd1;
          end
          pos2_q <= pos1_q;
          if (comp_q == '0) begin
            pos1_q <= node_pos_i;
          end
        end
      end else begin
        if (comp_q == '0) begin
          pos2_q <= pos1_q;
          pos1_q <= node_pos_i;
        end
        comp_q <= comp_q + CDR_COMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      l_q     <= left_mem[comp_q];
      m_q     <= cent_mem[comp_q];
      src_q   <= src_mem[comp_q];
      dif_q   <= dif_mem[comp_q];
      vel_q   <= vel_mem[comp_q];
      left_mem[comp_q] <= cent_mem[comp_q];
      cent_mem[comp_q] <= value_i;
      src_mem[comp_q]  <= src_term_i;
      dif_mem[comp_q]  <= diff_coef_i;
      vel_mem[comp_q]  <= velocity_i;
      r_q     <= value_i;
      d_q     <= $signed({1'b0, node_pos_i}) - $signed({1'b0, pos2_q});
      lastn_q <= last_node_i;
      cidx_q  <= comp_q;
      ph_q    <= phase_q;
    end
  end

  assign d_abs = d_q[32] ? 33'(-d_q) : d_q;

  cdr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.op == OP_DIV_START),
    .divisor_i (d_abs[31:0]),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_comb begin
    if (!d_q[32]) begin
      inv_new = (quot > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : quot[31:0];
    end else begin
      inv_new = (quot >= 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(quot[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= '0;
      q_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_CLR_INV: begin
          inv_q <= '0;
          q_q   <= '0;
        end
        OP_SET_INV: inv_q <= inv_new;
        OP_QSAT:    q_q <= sat32(prod_q >>> 14);
        default: ;
      endcase
    end
  end

  // One shared multiplier; each product is registered before scaling.
  always_comb begin
    case (cmd_i.op)
      OP_QMUL: begin
        mul_a = 34'(inv_q);
        mul_b = inv_q;
      end
      OP_M1: begin
        mul_a = 34'(r_q) - 34'(l_q);
        mul_b = inv_q;
      end
      OP_M2: begin
        mul_a = 34'(r_q) - (34'(m_q) <<< 1) + 34'(l_q);
        mul_b = q_q;
      end
      OP_M3: begin
        mul_a = 34'(vel_q);
        mul_b = ux_q;
      end
      default: begin
        mul_a = 34'(dif_q);
        mul_b = uxx_q;
      end
    endcase
  end

  assign prod_sat = sat32(prod_q >>> 16);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_QMUL, OP_M1: prod_q <= mul_a * mul_b;
      OP_M2: begin
        ux_q   <= prod_sat;
        prod_q <= mul_a * mul_b;
      end
      OP_M3: begin
        uxx_q  <= prod_sat;
        prod_q <= mul_a * mul_b;
      end
      OP_M4: begin
        pv_q   <= prod_sat;
        prod_q <= mul_a * mul_b;
      end
      OP_M5: pd_q <= prod_sat;
      default: ;
    endcase
  end

  assign res_sum = sat32(66'(src_q) + 66'(pd_q) - 66'(pv_q));
  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT_EDGE || cmd_i.op == OP_OUT_RES ||
                 cmd_i.op == OP_OUT_RIGHT) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_OUT_EDGE: begin
        out_res_q  <= '0;
        out_comp_q <= cidx_q;
        out_st_q   <= lastn_q ? ST_TOO_FEW : ST_OK;
        out_last_q <= 1'b1;
      end
      OP_OUT_RES: begin
        out_res_q  <= (inv_q == '0) ? 32'sd0 : res_sum;
        out_comp_q <= cidx_q;
        out_st_q   <= (inv_q == '0) ? ST_ZERO_SP : ST_OK;
        out_last_q <= !lastn_q;
      end
      OP_OUT_RIGHT: begin
        out_res_q  <= '0;
        out_comp_q <= cidx_q;
        out_st_q   <= ST_OK;
        out_last_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign sts_o.phase      = ph_q;
  assign sts_o.first_comp = (cidx_q == '0);
  assign sts_o.last_node  = lastn_q;
  assign sts_o.d_zero     = (d_q == '0);
  assign sts_o.inv_zero   = (inv_q == '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_vld_q;
  assign residual_o  = out_res_q;
  assign component_o = out_comp_q;
  assign status_o    = out_st_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT_EDGE || cmd_i.op == OP_OUT_RES || cmd_i.op == OP_OUT_RIGHT)
    |-> out_free) else $error("result register overwritten");
  a_no_mul_zero_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_M1) |-> (inv_q != '0)) else $error("residual math on zero spacing");
`endif

endmodule
`default_nettype wire

/* src/cdr_ctrl.sv */
// Controller that sequences one item through the datapath.
`default_nettype none
module cdr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cdr_pkg::dp_sts_t sts_i,
  output cdr_pkg::dp_cmd_t cmd_o
);
  import cdr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_DIV, S_QMUL, S_QSAT, S_CALC,
    S_M2, S_M3, S_M4, S_M5, S_EDGE, S_RES, S_RIGHT
  } state_e;

  state_e state_q, state_d;
  dp_op_e op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        if (sts_i.phase == 2'd0) begin
          state_d = S_EDGE;
        end else if (sts_i.phase == 2'd1) begin
          state_d = sts_i.last_node ? S_EDGE : S_IDLE;
        end else if (!sts_i.first_comp) begin
          state_d = S_CALC;
        end else if (sts_i.d_zero) begin
          op      = OP_CLR_INV;
          state_d = S_CALC;
        end else begin
          op      = OP_DIV_START;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          op      = OP_SET_INV;
          state_d = S_QMUL;
        end
      end
      S_QMUL: begin
        op      = OP_QMUL;
        state_d = S_QSAT;
      end
      S_QSAT: begin
        op      = OP_QSAT;
        state_d = S_CALC;
      end
      S_CALC: begin
        if (sts_i.inv_zero) begin
          state_d = S_RES;
        end else begin
          op      = OP_M1;
          state_d = S_M2;
        end
      end
      S_M2: begin
        op      = OP_M2;
        state_d = S_M3;
      end
      S_M3: begin
        op      = OP_M3;
        state_d = S_M4;
      end
      S_M4: begin
        op      = OP_M4;
        state_d = S_M5;
      end
      S_M5: begin
        op      = OP_M5;
        state_d = S_RES;
      end
      S_EDGE: begin
        if (sts_i.out_free) begin
          op      = OP_OUT_EDGE;
          state_d = S_IDLE;
        end
      end
      S_RES: begin
        if (sts_i.out_free) begin
          op      = OP_OUT_RES;
          state_d = sts_i.last_node ? S_RIGHT : S_IDLE;
        end
      end
      S_RIGHT: begin
        if (sts_i.out_free) begin
          op      = OP_OUT_RIGHT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign cmd_o.accept = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.op     = op;

`ifndef SYNTHESIS
  a_div_result_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_SET_INV) |=> (state_q == S_QMUL)) else $error("reciprocal not scaled");
`endif

endmodule
`default_nettype wire

/* src/central_difference_residual.sv */
// Top level of the three-point central-difference residual stream.
//
//  channel  direction  handshake                   payload
//  s_axis   in         s_axis_tvalid/s_axis_tready  tdata: value, node_pos, src_term,
//                                                    diff_coef, velocity; tlast: last_node
//  m_axis   out        m_axis_tvalid/m_axis_tready  tdata: residual, component, status;
//                                                    tlast: last
//  cfg      in         cfg_valid_i/cfg_ready_o      pde_count
//
// A first-node item ends in an edge result; a second-node item, in a result only
// if it ends the grid. An inner component runs steps M1 to M5 (none at zero
// spacing); a right edge adds a result. An inner node's first component first
// forms the reciprocal of a nonzero spacing (one-bit-per-cycle divider, 33 steps)
// and its square. All products go through a single shared multiplier. A result
// register decouples the output; a stalled output only blocks the next item once
// a new result must be written. Reset clears all control state.
`default_nettype none
module central_difference_residual (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // value [31:0], node_pos [63:32], src_term [95:64], diff_coef [127:96],
  // velocity [159:128]
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // residual [31:0], component [35:32], status [37:36], zero fill [39:38]
  output logic [39:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i
);
  import cdr_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic signed [31:0] residual;
  logic [3:0]         component;
  logic [1:0]         status;

  assign cfg_ready_o = 1'b1;

  cdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cdr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (s_axis_tdata[31:0]),
    .node_pos_i  (s_axis_tdata[63:32]),
    .src_term_i  (s_axis_tdata[95:64]),
    .diff_coef_i (s_axis_tdata[127:96]),
    .velocity_i  (s_axis_tdata[159:128]),
    .last_node_i (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .residual_o  (residual),
    .component_o (component),
    .status_o    (status),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, status, component, residual};

endmodule
`default_nettype wire

/* verif/tb_central_difference_residual.sv */
// Testbench for the central-difference residual stream: random grids checked against a predictor.
module tb_central_difference_residual;
  import cdr_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] node_pos;
    logic [31:0] src_term;
    logic [31:0] diff_coef;
    logic [31:0] velocity;
    logic        last_node;
  } grid_item_t;

  typedef struct packed {
    logic [31:0] residual;
    logic [3:0]  component;
    logic [1:0]  status;
    logic        last;
  } residual_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [4:0]   cfg_data_i = 5'd0;

  central_difference_residual u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial forever #10 clk_i = ~clk_i;

  grid_item_t  pending_items[$];
  residual_t   expected_residuals[$];
  grid_item_t  cur_item = '0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          no_idle = 1'b0;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  // Predictor state.
  logic [4:0]         pde_count_q = 5'd1;
  logic signed [31:0] left_q[16];
  logic signed [31:0] center_q[16];
  logic signed [31:0] src_q[16];
  logic signed [31:0] diff_q[16];
  logic signed [31:0] vel_q[16];
  logic [31:0]        pos_two_q = '0;
  logic [31:0]        pos_one_q = '0;
  logic signed [31:0] inv_spacing_q = '0;
  int unsigned        comp_idx_q = 0;
  int unsigned        phase_q = 0;

  assign s_axis_tdata = {cur_item.velocity, cur_item.diff_coef, cur_item.src_term,
                         cur_item.node_pos, cur_item.value};
  assign s_axis_tlast = cur_item.last_node;

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
    if (v > 80'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -80'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // floor(a * b / 2^16), saturated.
  function automatic logic signed [31:0] mul_q16(input logic signed [47:0] a,
                                                  input logic signed [31:0] b);
    logic signed [79:0] p;
    p = a * b;
    return clamp32(p >>> 16);
  endfunction

  task automatic push_result(input logic signed [31:0] r, input int unsigned c,
                             input logic [1:0] st, input logic l);
    residual_t e;
    e.residual = r;
    e.component = c[3:0];
    e.status = st;
    e.last = l;
    expected_residuals.push_back(e);
  endtask

  task automatic predict_residuals(input grid_item_t it);
    int unsigned        n;
    int unsigned        c;
    longint             d;
    longint             quo;
    logic signed [47:0] a4;
    logic signed [47:0] du;
    logic signed [47:0] d2u;
    logic signed [31:0] q;
    logic signed [31:0] ux;
    logic signed [31:0] uxx;
    logic signed [79:0] acc;
    logic signed [31:0] r;
    r = it.value;
    n = pde_count_q;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    if (comp_idx_q >= 16) comp_idx_q = 0;
    c = comp_idx_q;
    if (phase_q >= 2 && c == 0) begin
      d = longint'({32'b0, it.node_pos}) - longint'({32'b0, pos_two_q});
      if (d == 0) begin
        inv_spacing_q = '0;
      end else begin
        quo = 64'sd4294967296 / d;
        inv_spacing_q = clamp32(80'(quo));
      end
    end
    if (phase_q == 0) begin
      push_result('0, c, it.last_node ? ST_TOO_FEW : ST_OK, 1'b1);
    end else if (phase_q == 1) begin
      if (it.last_node) push_result('0, c, ST_TOO_FEW, 1'b1);
    end else begin
      if (inv_spacing_q == 0) begin
        push_result('0, c, ST_ZERO_SP, !it.last_node);
      end else begin
        a4 = inv_spacing_q;
        a4 = a4 <<< 2;
        q = mul_q16(a4, inv_spacing_q);
        du = 48'(r) - 48'(left_q[c]);
        d2u = 48'(r) - 48'(center_q[c]) - 48'(center_q[c]) + 48'(left_q[c]);
        ux = mul_q16(du, inv_spacing_q);
        uxx = mul_q16(d2u, q);
        acc = 80'(src_q[c]) + 80'(mul_q16(48'(diff_q[c]), uxx))
              - 80'(mul_q16(48'(vel_q[c]), ux));
        push_result(clamp32(acc), c, ST_OK, !it.last_node);
      end
      if (it.last_node) push_result('0, c, ST_OK, 1'b1);
    end
    left_q[c] = center_q[c];
    center_q[c] = r;
    src_q[c] = it.src_term;
    diff_q[c] = it.diff_coef;
    vel_q[c] = it.velocity;
    if (c + 1 >= n) begin
      comp_idx_q = 0;
      if (it.last_node) begin
        phase_q = 0;
        pos_two_q = '0;
        pos_one_q = '0;
      end else begin
        if (phase_q < 2) phase_q++;
        pos_two_q = pos_one_q;
        if (c == 0) pos_one_q = it.node_pos;
      end
    end else begin
      if (c == 0) begin
        pos_two_q = pos_one_q;
        pos_one_q = it.node_pos;
      end
      comp_idx_q = c + 1;
    end
  endtask

  // Input driver; the item is predicted at the edge where it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_residuals(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          if (!no_idle && $urandom_range(0, 11) == 0) begin
            send_gap <= $urandom_range(1, 19) - 1;
            s_axis_tvalid <= 1'b0;
          end else begin
            cur_item <= pending_items.pop_front();
            s_axis_tvalid <= 1'b1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output stall pattern and result checker.
  always @(posedge clk_i or negedge rst_ni) begin
    residual_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_residuals.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          fail_count++;
        end else begin
          e = expected_residuals.pop_front();
          if (m_axis_tdata[31:0] !== e.residual) begin
            $error("residual expected %h actual %h", e.residual, m_axis_tdata[31:0]);
            fail_count++;
          end
          if (m_axis_tdata[35:32] !== e.component) begin
            $error("component expected %0d actual %0d", e.component, m_axis_tdata[35:32]);
            fail_count++;
          end
          if (m_axis_tdata[37:36] !== e.status) begin
            $error("status expected %0d actual %0d", e.status, m_axis_tdata[37:36]);
            fail_count++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last expected %0b actual %0b", e.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("tb_central_difference_residual failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  // One grid of the given node count; most spacings are small and positive.
  task automatic queue_grid(input int nodes, input int ncomp, input bit noise);
    grid_item_t  it;
    logic [31:0] pos;
    pos = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
    for (int k = 0; k < nodes; k++) begin
      if (k > 0) begin
        case ($urandom_range(0, 9))
          0: pos = pos;
          1: pos = $urandom;
          2: pos = pos - $urandom_range(1, 1 << 17);
          3: pos = pos + 1;
          default: pos = pos + $urandom_range(1 << 12, 1 << 18);
        endcase
      end
      for (int c = 0; c < ncomp; c++) begin
        it.value = rand_word();
        it.node_pos = (c == 0) ? pos : $urandom;
        it.src_term = rand_word();
        it.diff_coef = rand_word();
        it.velocity = rand_word();
        it.last_node = (k == nodes - 1) || (noise && c + 1 < ncomp &&
                                            $urandom_range(0, 15) == 0);
        pending_items.push_back(it);
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_residuals.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_pde_count(input logic [4:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pde_count_q = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int eff_count(input logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  initial begin
    int sent;
    int ncomp;
    logic [4:0] setting;
    grid_item_t it;
    for (int i = 0; i < 16; i++) begin
      left_q[i] = '0; center_q[i] = '0; src_q[i] = '0; diff_q[i] = '0; vel_q[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lone nodes, two-node grids, zero spacing and full-scale fields.
    it = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
           32'h8000_0000, 1'b1};
    pending_items.push_back(it);
    queue_grid(2, 1, 0);
    it = '{32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b0};
    pending_items.push_back(it);
    it.node_pos = 32'h0002_0000;
    it.value = 32'h7FFF_FFFF;
    pending_items.push_back(it);
    it.node_pos = 32'h0003_0000;
    it.value = 32'h8000_0000;
    it.last_node = 1'b1;
    pending_items.push_back(it);
    for (int k = 0; k < 4; k++) begin
      it = '{32'(k << 16), 32'h0005_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, k == 3};
      pending_items.push_back(it);
    end
    queue_grid(5, 1, 0);
    write_pde_count(5'd0);
    queue_grid(3, 1, 0);
    write_pde_count(5'd16);
    queue_grid(3, 16, 0);
    write_pde_count(5'd31);
    queue_grid(3, 16, 0);

    // Random grids under a sequence of settings.
    sent = 0;
    while (sent < 600) begin
      setting = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 4));
      write_pde_count(setting);
      ncomp = eff_count(setting);
      for (int g = 0; g < 4; g++) begin
        int nodes;
        nodes = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        queue_grid(nodes, ncomp, $urandom_range(0, 3) == 0);
        sent += nodes * ncomp;
      end
    end
    write_pde_count(5'd1);
    no_idle = 1'b1;
    for (int g = 0; g < 8; g++) queue_grid($urandom_range(3, 6), 1, 0);
    drain();
    if (fail_count == 0) begin
      $display("tb_central_difference_residual passed");
    end else begin
      $display("tb_central_difference_residual failed");
    end
    $finish;
  end

endmodule
